FILE: rtl/core/rtcu_pkg.sv
package rtcu_pkg;

    // Status B bits and the 12-hour PM flag.
    localparam logic [7:0] MODE_BINARY = 8'h04;
    localparam logic [7:0] MODE_H24    = 8'h02;
    localparam logic [7:0] HOUR_PM     = 8'h80;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FIELD  = 2'd1;
    localparam logic [1:0] STATUS_WINDOW = 2'd2;

    localparam int          EPOCH_W      = 33;
    localparam logic [32:0] EPOCH_RESET  = 33'd1767225600;
    localparam logic [33:0] WINDOW_SPAN  = 34'd630720000;
    localparam logic [32:0] SECS_PER_DAY = 33'd86400;
    // Days from 1970-01-01 to 2000-01-01.
    localparam logic [15:0] DAYS_TO_2000 = 16'd10957;

    typedef struct packed {
        logic [7:0] sec_reg;
        logic [7:0] min_reg;
        logic [7:0] hour_reg;
        logic [7:0] day_reg;
        logic [7:0] month_reg;
        logic [7:0] year_reg;
        logic [7:0] mode_reg;
    } rtcu_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] unix_seconds;
    } rtcu_out_t;

    // Decoded and checked calendar fields.
    typedef struct packed {
        logic       bad;
        logic [6:0] yr;
        logic [3:0] mon;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] min;
        logic [5:0] sec;
    } rtcu_dec_t;

    // Day count and second of day.
    typedef struct packed {
        logic        bad;
        logic [15:0] days;
        logic [16:0] sod;
    } rtcu_dt_t;

    function automatic logic [7:0] bcd_val(input logic [7:0] v);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = {4'b0, v[3:0]};
        hi = {4'b0, v[7:4]};
        return lo + hi * 8'd10;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
            4'd2:                                      r = 5'd28;
            default:                                   r = 5'd0;
        endcase
        return r;
    endfunction

    // Days in a common year before the first of the month.
    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/cmos_rtc_to_unix_time.sv
// Channel   Signals                    Transfer
// input     start, busy, item          start high and busy low at a rising edge
// result    done, result               done high for one cycle, always taken
// config    cfg_wr_en, cfg_wr_data     cfg_wr_en high at a rising edge
//
// One register set can be taken every cycle; busy is never raised.
// Each result passes through the four register stages: decode and check,
// day count, seconds multiply, window compare.
// Reset clears the stage valid bits and loads the default epoch floor.
// The receiver has no way to stall, so no item waits inside the pipeline.
module cmos_rtc_to_unix_time
    import rtcu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rtcu_in_t           item,
    output logic               done,
    output rtcu_out_t          result,
    input  logic               cfg_wr_en,
    input  logic [EPOCH_W-1:0] cfg_wr_data
);

    logic [EPOCH_W-1:0] epoch_floor_reg;
    logic               dec_valid;
    rtcu_dec_t          dec;
    logic               dt_valid;
    rtcu_dt_t           dt;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            epoch_floor_reg <= EPOCH_RESET;
        else if (cfg_wr_en)
            epoch_floor_reg <= cfg_wr_data;
    end

    rtcu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .item      (item),
        .dec_valid (dec_valid),
        .dec       (dec)
    );

    rtcu_datecalc u_datecalc (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec       (dec),
        .dt_valid  (dt_valid),
        .dt        (dt)
    );

    rtcu_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .dt_valid    (dt_valid),
        .dt          (dt),
        .epoch_floor (epoch_floor_reg),
        .done        (done),
        .result      (result)
    );

`ifndef ASSERT_OFF
    // Every accepted register set yields a result.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted item produced no result after four cycles");

    // A result never appears without a matching accepted item.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result without a matching transfer");

    // Seconds are reported only with an ok status.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == STATUS_OK || result.unix_seconds == 32'd0))
        else $error("nonzero seconds with an error status");
`endif

endmodule

FILE: rtl/core/rtcu_decode.sv
module rtcu_decode
    import rtcu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  rtcu_in_t  item,
    output logic      dec_valid,
    output rtcu_dec_t dec
);

    logic      valid_reg;
    rtcu_dec_t dec_reg;
    rtcu_dec_t dec_next;

    logic       binary;
    logic       h24;
    logic       pm;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] yr;
    logic [7:0] hour_bits;
    logic [4:0] limit;
    logic       range_bad;

    always_comb
    begin
        binary    = (item.mode_reg & MODE_BINARY) != 8'd0;
        h24       = (item.mode_reg & MODE_H24) != 8'd0;
        pm        = !h24 && ((item.hour_reg & HOUR_PM) != 8'd0);
        hour_bits = item.hour_reg & ~HOUR_PM;

        sec  = binary ? item.sec_reg   : bcd_val(item.sec_reg);
        min  = binary ? item.min_reg   : bcd_val(item.min_reg);
        hour = binary ? hour_bits      : bcd_val(hour_bits);
        day  = binary ? item.day_reg   : bcd_val(item.day_reg);
        mon  = binary ? item.month_reg : bcd_val(item.month_reg);
        yr   = binary ? item.year_reg  : bcd_val(item.year_reg);

        // Twelve o'clock is hour zero in the AM half; other PM hours move up by 12.
        if (!h24)
        begin
            if (hour == 8'd12)
                hour = pm ? 8'd12 : 8'd0;
            else if (pm)
                hour = hour + 8'd12;
        end

        range_bad = (yr > 8'd99) || (mon < 8'd1) || (mon > 8'd12) || (day < 8'd1) ||
                    (day > 8'd31) || (hour > 8'd23) || (min > 8'd59) || (sec > 8'd60);

        // Within 2000..2099 the leap years are exactly the multiples of four.
        limit = month_len(mon[3:0]);
        if (mon == 8'd2 && yr[1:0] == 2'b00)
            limit = 5'd29;

        dec_next.bad  = range_bad || (day[4:0] > limit);
        dec_next.yr   = yr[6:0];
        dec_next.mon  = mon[3:0];
        dec_next.day  = day[4:0];
        dec_next.hour = hour[4:0];
        dec_next.min  = min[5:0];
        dec_next.sec  = sec[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

FILE: rtl/core/rtcu_datecalc.sv
module rtcu_datecalc
    import rtcu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      dec_valid,
    input  rtcu_dec_t dec,
    output logic      dt_valid,
    output rtcu_dt_t  dt
);

    logic     valid_reg;
    rtcu_dt_t dt_reg;
    rtcu_dt_t dt_next;

    logic [15:0] year_days;
    logic [15:0] leap_days;
    logic [15:0] month_days;
    logic        leap_adj;

    always_comb
    begin
        // Leap days of the years 2000 .. 2000+yr-1.
        year_days  = 16'(dec.yr) * 16'd365;
        leap_days  = (16'(dec.yr) + 16'd3) >> 2;
        leap_adj   = (dec.yr[1:0] == 2'b00) && (dec.mon > 4'd2);
        month_days = 16'(days_before_month(dec.mon)) + 16'(leap_adj);

        dt_next.bad  = dec.bad;
        dt_next.days = DAYS_TO_2000 + year_days + leap_days + month_days
                     + 16'(dec.day) - 16'd1;
        dt_next.sod  = 17'(dec.hour) * 17'd3600 + 17'(dec.min) * 17'd60 + 17'(dec.sec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= dec_valid;
    end

    always_ff @(posedge clk)
    begin
        dt_reg <= dt_next;
    end

    assign dt_valid = valid_reg;
    assign dt       = dt_reg;

endmodule

FILE: rtl/core/rtcu_window.sv
module rtcu_window
    import rtcu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               dt_valid,
    input  rtcu_dt_t           dt,
    input  logic [EPOCH_W-1:0] epoch_floor,
    output logic               done,
    output rtcu_out_t          result
);

    // Stage three: full time in seconds.
    logic        t_valid_reg;
    logic        t_bad_reg;
    logic [31:0] t_reg;
    logic [31:0] t_next;
    logic [32:0] day_secs;

    // Stage four: window check and result.
    logic      done_reg;
    rtcu_out_t result_reg;
    rtcu_out_t result_next;
    logic [33:0] ceiling;
    logic        outside;

    always_comb
    begin
        day_secs = 33'(dt.days) * SECS_PER_DAY;
        t_next   = 32'(day_secs + 33'(dt.sod));
    end

    always_comb
    begin
        ceiling = 34'(epoch_floor) + WINDOW_SPAN;
        outside = (33'(t_reg) < epoch_floor) || (34'(t_reg) > ceiling);
        if (t_bad_reg)
        begin
            result_next.status       = STATUS_FIELD;
            result_next.unix_seconds = 32'd0;
        end
        else if (outside)
        begin
            result_next.status       = STATUS_WINDOW;
            result_next.unix_seconds = 32'd0;
        end
        else
        begin
            result_next.status       = STATUS_OK;
            result_next.unix_seconds = t_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            t_valid_reg <= dt_valid;
            done_reg    <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_bad_reg  <= dt.bad;
        t_reg      <= t_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
